### rtl/core/mmas_pkg.sv
`default_nettype none
package mmas_pkg;

	localparam int RES_W      = 40;
	localparam int ACC_W      = 64;
	localparam int FRAC_SHIFT = 8;
	localparam int RESULT_CAP = 64;
	localparam int RCW        = 7;

	localparam logic [1:0] MODE_MUL = 2'd0;
	localparam logic [1:0] MODE_ADD = 2'd1;
	localparam logic [1:0] MODE_SUB = 2'd2;

	localparam logic [2:0] REG_MODE   = 3'd0;
	localparam logic [2:0] REG_ROWS_A = 3'd1;
	localparam logic [2:0] REG_COLS_A = 3'd2;
	localparam logic [2:0] REG_ROWS_B = 3'd3;
	localparam logic [2:0] REG_COLS_B = 3'd4;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ERR,
		ST_LOAD,
		ST_RUN,
		ST_DRAIN
	} state_t;

	// control bits travelling with each stream item along the cell row
	typedef struct packed {
		logic vld;
		logic first;
		logic fin;
		logic mul;
		logic sub;
	} tag_t;

	function automatic logic signed [ACC_W-1:0] clamp61(input logic signed [ACC_W-1:0] v);
		logic signed [ACC_W-1:0] b;
		b = 64'sd1 <<< 61;
		if (v > b)
			return b;
		if (v < -b)
			return -b;
		return v;
	endfunction

	function automatic logic signed [RES_W-1:0] sat40(input logic signed [ACC_W-1:0] v);
		logic signed [ACC_W-1:0] hi;
		logic signed [ACC_W-1:0] lo;
		hi = (64'sd1 <<< 39) - 64'sd1;
		lo = -(64'sd1 <<< 39);
		if (v > hi)
			return hi[RES_W-1:0];
		if (v < lo)
			return lo[RES_W-1:0];
		return v[RES_W-1:0];
	endfunction

endpackage
`default_nettype wire

### rtl/core/mmas_mem.sv
`default_nettype none
module mmas_mem #(
	parameter int W     = 16,
	parameter int DEPTH = 64,
	parameter int AW    = 6
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire logic [W-1:0]  wdata,
	input  wire logic          re,
	input  wire logic [AW-1:0] raddr,
	output logic      [W-1:0]  rdata_q
);

	logic [W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
	end

	always_ff @(posedge clk) begin
		if (re)
			rdata_q <= mem[raddr];
	end

endmodule
`default_nettype wire

### rtl/core/mmas_cell.sv
`default_nettype none
module mmas_cell #(
	parameter int EW       = 16,
	parameter int IW       = 3,
	parameter int DW       = 4,
	parameter int MAX_DIM  = 8,
	parameter int CELL_IDX = 0
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              en,
	input  wire logic                              sh,
	input  wire logic signed [EW-1:0]              sh_in,
	output logic signed      [EW-1:0]              sh_out,
	input  wire logic        [DW-1:0]              oc,
	input  wire mmas_pkg::tag_t                    tag_in,
	input  wire logic signed [EW-1:0]              a_in,
	input  wire logic        [IW-1:0]              k_in,
	input  wire logic        [IW-1:0]              i_in,
	output mmas_pkg::tag_t                         tag_out,
	output logic signed      [EW-1:0]              a_out,
	output logic             [IW-1:0]              k_out,
	output logic             [IW-1:0]              i_out,
	output logic                                   res_vld,
	output logic signed      [mmas_pkg::RES_W-1:0] res_val,
	output logic             [IW-1:0]              res_row
);

	// this cell's column of B, shifted in from the right during preload
	logic signed [EW-1:0] col_q [MAX_DIM];

	mmas_pkg::tag_t                     tag_q;
	logic signed [EW-1:0]               a_q;
	logic        [IW-1:0]               k_q;
	logic        [IW-1:0]               i_q;

	logic                               act;
	logic signed [EW-1:0]               b_sel;
	logic signed [2*EW-1:0]             prod;
	logic signed [EW:0]                 pm;
	logic signed [mmas_pkg::ACC_W-1:0]  term;

	logic                               s1_vld_s1;
	logic                               s1_first_s1;
	logic                               s1_fin_s1;
	logic        [IW-1:0]               row_s1;
	logic signed [mmas_pkg::ACC_W-1:0]  term_s1;

	logic signed [mmas_pkg::ACC_W-1:0]  acc_q;
	logic signed [mmas_pkg::ACC_W-1:0]  sum;
	logic                               res_vld_q;
	logic        [IW-1:0]               res_row_q;

	always_ff @(posedge clk) begin
		if (sh) begin
			for (int m = 0; m < MAX_DIM - 1; m++)
				col_q[m] <= col_q[m+1];
			col_q[MAX_DIM-1] <= sh_in;
		end
	end

	assign sh_out = col_q[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_q     <= '0;
			s1_vld_s1 <= 1'b0;
			res_vld_q <= 1'b0;
		end else if (en) begin
			tag_q     <= tag_in;
			s1_vld_s1 <= tag_in.vld && act;
			res_vld_q <= s1_vld_s1 && s1_fin_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			a_q         <= a_in;
			k_q         <= k_in;
			i_q         <= i_in;
			s1_first_s1 <= tag_in.first;
			s1_fin_s1   <= tag_in.fin;
			row_s1      <= i_in;
			term_s1     <= term;
			res_row_q   <= row_s1;
			if (s1_vld_s1)
				acc_q <= mmas_pkg::clamp61(sum);
		end
	end

	assign act   = DW'(CELL_IDX) < oc;
	assign b_sel = tag_in.mul ? col_q[k_in] : col_q[i_in];
	assign prod  = a_in * b_sel;
	assign pm    = tag_in.sub ? ((EW+1)'(a_in) - (EW+1)'(b_sel))
	                          : ((EW+1)'(a_in) + (EW+1)'(b_sel));

	// sum and difference: only the item whose column matches this cell counts
	always_comb begin
		if (tag_in.mul)
			term = mmas_pkg::ACC_W'(prod);
		else if (k_in == IW'(CELL_IDX))
			term = mmas_pkg::ACC_W'(pm) <<< mmas_pkg::FRAC_SHIFT;
		else
			term = '0;
	end

	assign sum = (s1_first_s1 ? '0 : acc_q) + mmas_pkg::clamp61(term_s1);

	assign tag_out = tag_q;
	assign a_out   = a_q;
	assign k_out   = k_q;
	assign i_out   = i_q;
	assign res_vld = res_vld_q;
	assign res_val = mmas_pkg::sat40(acc_q);
	assign res_row = res_row_q;

endmodule
`default_nettype wire

### rtl/core/matrix_multiply_add_sub.sv
// Matrix product, sum or difference over two streamed matrices.
// Input channel (in_valid/in_ready): one element per item, kind 0 for A,
// kind 1 for B, each in row-major order, signed Q8.8. Elements beyond a
// matrix's size are dropped. Loading takes one item per cycle.
// The item that fills both matrices starts a run and in_ready drops.
// A run first copies B into a row of MAX_DIM column cells, then streams
// A rows through the cells, at most one element a cycle and only while the
// output is not stalled; result column j of a row shows on out_valid once
// the row's last A element has passed cell j and the output register.
// A drain state follows, after which loading resumes.
// A dimension mismatch or mode 3 gives a single error result instead.
// Output channel (out_valid/out_ready): signed Q24.16 result with row, col,
// last and error. On a receiver stall the cell stream freezes, B preload does not.
// Configuration (cfg_valid/cfg_ready/cfg_index/cfg_data) is always ready
// and must only be written while no run is in progress.
// Reset clears the fill counts, sets mode to multiply and all dimensions to
// 8; the element stores are not cleared.
`default_nettype none
module matrix_multiply_add_sub #(
	parameter int MAX_DIM    = 8,
	parameter int ELEM_WIDTH = 16
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire logic                 kind,
	input  wire logic signed [15:0]   value,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output logic signed      [39:0]   result_value,
	output logic             [2:0]    row,
	output logic             [2:0]    col,
	output logic                      last,
	output logic                      error,
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic        [2:0]    cfg_index,
	input  wire logic        [3:0]    cfg_data
);

	localparam int EW      = ELEM_WIDTH;
	localparam int IW      = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
	localparam int DW      = $clog2(MAX_DIM + 1);
	localparam int SW      = 2 * DW;
	localparam int DEPTH   = MAX_DIM * MAX_DIM;
	localparam int AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int DRAIN_N = MAX_DIM + 4;
	localparam int NW      = $clog2(DRAIN_N + 1);
	localparam int RCW     = mmas_pkg::RCW;

	function automatic logic [DW-1:0] dim_of(input logic [3:0] r);
		if (r == 4'd0)
			return DW'(1);
		if (int'(r) > MAX_DIM)
			return DW'(MAX_DIM);
		return DW'(r);
	endfunction

	// configuration
	logic [1:0] mode_q;
	logic [3:0] rows_a_q, cols_a_q, rows_b_q, cols_b_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= mmas_pkg::MODE_MUL;
			rows_a_q <= 4'd8;
			cols_a_q <= 4'd8;
			rows_b_q <= 4'd8;
			cols_b_q <= 4'd8;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				mmas_pkg::REG_MODE:   mode_q   <= cfg_data[1:0];
				mmas_pkg::REG_ROWS_A: rows_a_q <= cfg_data;
				mmas_pkg::REG_COLS_A: cols_a_q <= cfg_data;
				mmas_pkg::REG_ROWS_B: rows_b_q <= cfg_data;
				mmas_pkg::REG_COLS_B: cols_b_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cfg_ready = 1'b1;

	logic [DW-1:0] ra, ca, rb, cb, oc, per;
	logic [SW-1:0] size_a, size_b, total_full;
	logic [RCW-1:0] total;
	logic is_mul, is_add, is_sub, dims_ok;

	assign ra     = dim_of(rows_a_q);
	assign ca     = dim_of(cols_a_q);
	assign rb     = dim_of(rows_b_q);
	assign cb     = dim_of(cols_b_q);
	assign size_a = SW'(ra) * SW'(ca);
	assign size_b = SW'(rb) * SW'(cb);
	assign is_mul = mode_q == mmas_pkg::MODE_MUL;
	assign is_add = mode_q == mmas_pkg::MODE_ADD;
	assign is_sub = mode_q == mmas_pkg::MODE_SUB;
	assign dims_ok = is_mul ? (ca == rb) :
	                 ((is_add || is_sub) ? (ra == rb && ca == cb) : 1'b0);
	assign oc     = is_mul ? cb : ca;
	assign per    = (ca > oc) ? ca : oc;
	assign total_full = SW'(ra) * SW'(oc);
	assign total  = (int'(total_full) > mmas_pkg::RESULT_CAP) ?
	                RCW'(mmas_pkg::RESULT_CAP) : RCW'(total_full);

	// loading
	mmas_pkg::state_t state_q, state_nx;
	logic [SW-1:0] count_a_q, count_b_q, count_a_nx, count_b_nx;
	logic acc_in, a_we, b_we, trigger;
	logic signed [EW-1:0] elem;

	assign in_ready = state_q == mmas_pkg::ST_IDLE;
	assign acc_in   = in_valid && in_ready;
	assign elem     = EW'(value);
	assign a_we     = acc_in && !kind && (count_a_q < size_a);
	assign b_we     = acc_in && kind && (count_b_q < size_b);
	assign count_a_nx = a_we ? count_a_q + SW'(1) : count_a_q;
	assign count_b_nx = b_we ? count_b_q + SW'(1) : count_b_q;
	assign trigger  = acc_in && (count_a_nx >= size_a) && (count_b_nx >= size_b);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_a_q <= '0;
			count_b_q <= '0;
		end else if (trigger) begin
			count_a_q <= '0;
			count_b_q <= '0;
		end else begin
			count_a_q <= count_a_nx;
			count_b_q <= count_b_nx;
		end
	end

	// stall: the stream past the stores moves only when the output can take; B preload does not stall
	logic en;
	logic out_valid_q;
	assign en = !out_valid_q || out_ready;

	// sequencer
	logic [IW-1:0] k_q, i_q, pj_q, pk_q;
	logic [AW-1:0] a_addr_q, b_addr;
	logic [NW-1:0] drain_q;
	logic load_end, run_end, drain_end, pv;
	mmas_pkg::tag_t issue;

	assign load_end  = (int'(pj_q) == MAX_DIM - 1) && (int'(pk_q) == MAX_DIM - 1);
	assign run_end   = (DW'(k_q) == per - DW'(1)) && (DW'(i_q) == ra - DW'(1));
	assign drain_end = int'(drain_q) == DRAIN_N - 1;
	assign pv        = (DW'(pk_q) < rb) && (DW'(pj_q) < cb);
	assign b_addr    = AW'(SW'(pk_q) * SW'(cb) + SW'(pj_q));

	always_comb begin
		issue       = '0;
		issue.vld   = (state_q == mmas_pkg::ST_RUN) && (DW'(k_q) < ca);
		issue.first = k_q == '0;
		issue.fin   = DW'(k_q) == ca - DW'(1);
		issue.mul   = is_mul;
		issue.sub   = is_sub;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= mmas_pkg::ST_IDLE;
		else
			state_q <= state_nx;
	end

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			mmas_pkg::ST_IDLE:
				if (trigger)
					state_nx = dims_ok ? mmas_pkg::ST_LOAD : mmas_pkg::ST_ERR;
			mmas_pkg::ST_ERR:
				if (en)
					state_nx = mmas_pkg::ST_IDLE;
			mmas_pkg::ST_LOAD:
				if (load_end)
					state_nx = mmas_pkg::ST_RUN;
			mmas_pkg::ST_RUN:
				if (en && run_end)
					state_nx = mmas_pkg::ST_DRAIN;
			mmas_pkg::ST_DRAIN:
				if (en && drain_end)
					state_nx = mmas_pkg::ST_IDLE;
			default:
				state_nx = mmas_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (state_q == mmas_pkg::ST_IDLE) begin
			k_q      <= '0;
			i_q      <= '0;
			pj_q     <= '0;
			pk_q     <= '0;
			a_addr_q <= '0;
			drain_q  <= '0;
		end else if (state_q == mmas_pkg::ST_LOAD) begin
			if (int'(pk_q) == MAX_DIM - 1) begin
				pk_q <= '0;
				pj_q <= pj_q + IW'(1);
			end else begin
				pk_q <= pk_q + IW'(1);
			end
		end else if (en) begin
			if (state_q == mmas_pkg::ST_RUN) begin
				if (issue.vld)
					a_addr_q <= a_addr_q + AW'(1);
				if (DW'(k_q) == per - DW'(1)) begin
					k_q <= '0;
					i_q <= i_q + IW'(1);
				end else begin
					k_q <= k_q + IW'(1);
				end
			end else if (state_q == mmas_pkg::ST_DRAIN) begin
				drain_q <= drain_q + NW'(1);
			end
		end
	end

	// element stores
	logic [EW-1:0] a_rd, b_rd;

	mmas_mem #(.W(EW), .DEPTH(DEPTH), .AW(AW)) u_store_a (
		.clk    (clk),
		.we     (a_we),
		.waddr  (count_a_q[AW-1:0]),
		.wdata  (elem),
		.re     (en),
		.raddr  (a_addr_q),
		.rdata_q(a_rd)
	);

	mmas_mem #(.W(EW), .DEPTH(DEPTH), .AW(AW)) u_store_b (
		.clk    (clk),
		.we     (b_we),
		.waddr  (count_b_q[AW-1:0]),
		.wdata  (elem),
		.re     (state_q == mmas_pkg::ST_LOAD),
		.raddr  (b_addr),
		.rdata_q(b_rd)
	);

	// preload push stage and feed stage into the first cell
	logic push_s1, pv_s1;
	mmas_pkg::tag_t feed_tag_s1;
	logic [IW-1:0] feed_k_s1, feed_i_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			push_s1     <= 1'b0;
			feed_tag_s1 <= '0;
		end else begin
			push_s1 <= state_q == mmas_pkg::ST_LOAD;
			if (en)
				feed_tag_s1 <= issue;
		end
	end

	always_ff @(posedge clk) begin
		pv_s1 <= pv;
		if (en) begin
			feed_k_s1 <= k_q;
			feed_i_s1 <= i_q;
		end
	end

	// cell row
	mmas_pkg::tag_t tag_c [MAX_DIM+1];
	logic signed [EW-1:0] a_c  [MAX_DIM+1];
	logic [IW-1:0]        k_c  [MAX_DIM+1];
	logic [IW-1:0]        i_c  [MAX_DIM+1];
	logic signed [EW-1:0] sh_c [MAX_DIM+1];
	logic                 res_vld [MAX_DIM];
	logic signed [mmas_pkg::RES_W-1:0] res_val [MAX_DIM];
	logic [IW-1:0]        res_row [MAX_DIM];

	assign tag_c[0]        = feed_tag_s1;
	assign a_c[0]          = a_rd;
	assign k_c[0]          = feed_k_s1;
	assign i_c[0]          = feed_i_s1;
	assign sh_c[MAX_DIM]   = pv_s1 ? b_rd : '0;

	for (genvar j = 0; j < MAX_DIM; j++) begin : g_cell
		mmas_cell #(
			.EW(EW), .IW(IW), .DW(DW), .MAX_DIM(MAX_DIM), .CELL_IDX(j)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.en      (en),
			.sh      (push_s1),
			.sh_in   (sh_c[j+1]),
			.sh_out  (sh_c[j]),
			.oc      (oc),
			.tag_in  (tag_c[j]),
			.a_in    (a_c[j]),
			.k_in    (k_c[j]),
			.i_in    (i_c[j]),
			.tag_out (tag_c[j+1]),
			.a_out   (a_c[j+1]),
			.k_out   (k_c[j+1]),
			.i_out   (i_c[j+1]),
			.res_vld (res_vld[j]),
			.res_val (res_val[j]),
			.res_row (res_row[j])
		);
	end

	// at most one cell finishes in any cycle
	logic res_any;
	logic signed [mmas_pkg::RES_W-1:0] sel_val;
	logic [2:0] sel_row, sel_col;

	always_comb begin
		res_any = 1'b0;
		sel_val = '0;
		sel_row = '0;
		sel_col = '0;
		for (int j = 0; j < MAX_DIM; j++) begin
			if (res_vld[j]) begin
				res_any = 1'b1;
				sel_val = res_val[j];
				sel_row = 3'(res_row[j]);
				sel_col = 3'(j);
			end
		end
	end

	// output register
	logic [RCW-1:0] n_q;
	logic signed [39:0] val_q;
	logic [2:0] row_q, col_q;
	logic last_q, err_q;
	logic take_err, take_res;

	assign take_err = (state_q == mmas_pkg::ST_ERR) && en;
	assign take_res = en && res_any && (n_q < total);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			n_q         <= '0;
		end else begin
			if (trigger)
				n_q <= '0;
			else if (take_res)
				n_q <= n_q + RCW'(1);
			if (take_err || take_res)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take_err) begin
			val_q  <= '0;
			row_q  <= '0;
			col_q  <= '0;
			last_q <= 1'b1;
			err_q  <= 1'b1;
		end else if (take_res) begin
			val_q  <= sel_val;
			row_q  <= sel_row;
			col_q  <= sel_col;
			last_q <= (n_q + RCW'(1)) == total;
			err_q  <= 1'b0;
		end
	end

	assign out_valid    = out_valid_q;
	assign result_value = val_q;
	assign row          = row_q;
	assign col          = col_q;
	assign last         = last_q;
	assign error        = err_q;

endmodule
`default_nettype wire

### dv/matrix_multiply_add_sub_tb.sv
`timescale 1ns / 1ps
module matrix_multiply_add_sub_tb;

	localparam logic       KIND_A   = 1'b0;
	localparam logic       KIND_B   = 1'b1;
	localparam logic [1:0] MODE_BAD = 2'd3;
	localparam int         DIM_MAX  = 8;
	localparam int         SETTLE   = 40;

	typedef struct {
		logic              kind;
		logic signed [15:0] value;
	} elem_t;

	typedef struct {
		logic signed [39:0] value;
		logic [2:0]         row;
		logic [2:0]         col;
		logic               last;
		logic               error;
	} result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic kind = 1'b0;
	logic signed [15:0] value = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [39:0] result_value;
	logic [2:0] row;
	logic [2:0] col;
	logic last;
	logic error;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [2:0] cfg_index = '0;
	logic [3:0] cfg_data = '0;

	matrix_multiply_add_sub DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .kind(kind), .value(value),
		.out_valid(out_valid), .out_ready(out_ready), .result_value(result_value),
		.row(row), .col(col), .last(last), .error(error),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #1 clk = ~clk;

	elem_t   pending_elems[$];
	result_t expected_results[$];
	int      fail_count = 0;
	bit      calm = 1'b0;
	logic    in_fire = 1'b0;
	logic    out_fire = 1'b0;

	// shadow of the block's registers and stores
	logic [1:0] sh_mode = mmas_pkg::MODE_MUL;
	logic [3:0] sh_rows_a = 4'd8, sh_cols_a = 4'd8, sh_rows_b = 4'd8, sh_cols_b = 4'd8;
	logic signed [15:0] store_a[64];
	logic signed [15:0] store_b[64];
	int fill_a = 0, fill_b = 0;

	function automatic int eff_dim(logic [3:0] r);
		if (r == 0)
			return 1;
		if (r > DIM_MAX)
			return DIM_MAX;
		return r;
	endfunction

	function automatic longint limit61(longint v);
		longint b;
		b = 64'sd1 <<< 61;
		if (v > b)
			return b;
		if (v < -b)
			return -b;
		return v;
	endfunction

	function automatic logic signed [39:0] clip40(longint v);
		longint hi;
		longint lo;
		hi = (64'sd1 <<< 39) - 1;
		lo = -(64'sd1 <<< 39);
		if (v > hi)
			v = hi;
		if (v < lo)
			v = lo;
		return v[39:0];
	endfunction

	task automatic load_and_compute(logic k, logic signed [15:0] v);
		int ra, ca, rb, cb, oc, total, n;
		longint acc, x, y;
		bit ok;
		result_t r;
		ra = eff_dim(sh_rows_a);
		ca = eff_dim(sh_cols_a);
		rb = eff_dim(sh_rows_b);
		cb = eff_dim(sh_cols_b);
		if (k == KIND_A) begin
			if (fill_a < ra * ca) begin
				store_a[fill_a] = v;
				fill_a++;
			end
		end else begin
			if (fill_b < rb * cb) begin
				store_b[fill_b] = v;
				fill_b++;
			end
		end
		if (fill_a < ra * ca || fill_b < rb * cb)
			return;
		fill_a = 0;
		fill_b = 0;
		unique case (sh_mode)
			mmas_pkg::MODE_MUL: ok = (ca == rb);
			mmas_pkg::MODE_ADD, mmas_pkg::MODE_SUB: ok = (ra == rb && ca == cb);
			default: ok = 1'b0;
		endcase
		if (!ok) begin
			r = '{value: '0, row: '0, col: '0, last: 1'b1, error: 1'b1};
			expected_results.push_back(r);
			return;
		end
		oc = (sh_mode == mmas_pkg::MODE_MUL) ? cb : ca;
		total = ra * oc;
		if (total > mmas_pkg::RESULT_CAP)
			total = mmas_pkg::RESULT_CAP;
		n = 0;
		for (int i = 0; i < ra && n < total; i++) begin
			for (int j = 0; j < oc && n < total; j++) begin
				if (sh_mode == mmas_pkg::MODE_MUL) begin
					acc = 0;
					for (int m = 0; m < ca; m++)
						acc = limit61(acc + limit61(longint'(store_a[i * ca + m]) *
							longint'(store_b[m * cb + j])));
				end else begin
					x = store_a[i * ca + j];
					y = store_b[i * ca + j];
					acc = ((sh_mode == mmas_pkg::MODE_ADD) ? (x + y) : (x - y)) * 256;
				end
				n++;
				r = '{value: clip40(acc), row: i[2:0], col: j[2:0],
					last: (n == total), error: 1'b0};
				expected_results.push_back(r);
			end
		end
	endtask

	// sampling, prediction and checking
	always @(posedge clk) begin
		in_fire <= in_valid && in_ready;
		out_fire <= out_valid && out_ready;
		if (arst_n) begin
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					mmas_pkg::REG_MODE: sh_mode = cfg_data[1:0];
					mmas_pkg::REG_ROWS_A: sh_rows_a = cfg_data;
					mmas_pkg::REG_COLS_A: sh_cols_a = cfg_data;
					mmas_pkg::REG_ROWS_B: sh_rows_b = cfg_data;
					mmas_pkg::REG_COLS_B: sh_cols_b = cfg_data;
					default: ;
				endcase
			end
			if (out_valid && out_ready) begin
				if (expected_results.size() == 0) begin
					$error("unexpected result value=%0d row=%0d col=%0d",
						result_value, row, col);
					fail_count++;
				end else begin
					result_t e;
					e = expected_results.pop_front();
					if (result_value !== e.value) begin
						$error("result_value: expected %0d, got %0d", e.value, result_value);
						fail_count++;
					end
					if (row !== e.row) begin
						$error("row: expected %0d, got %0d", e.row, row);
						fail_count++;
					end
					if (col !== e.col) begin
						$error("col: expected %0d, got %0d", e.col, col);
						fail_count++;
					end
					if (last !== e.last) begin
						$error("last: expected %0d, got %0d", e.last, last);
						fail_count++;
					end
					if (error !== e.error) begin
						$error("error: expected %0d, got %0d", e.error, error);
						fail_count++;
					end
				end
			end
			if (in_valid && in_ready)
				load_and_compute(kind, value);
		end
	end

	// element driver
	int in_gap = 0;
	always @(negedge clk) begin
		if (arst_n && (!in_valid || in_fire)) begin
			if (in_gap > 0) begin
				in_valid <= 1'b0;
				in_gap--;
			end else if (pending_elems.size() > 0) begin
				elem_t p;
				p = pending_elems.pop_front();
				in_valid <= 1'b1;
				kind <= p.kind;
				value <= p.value;
				in_gap = calm ? 0 : $urandom_range(0, 4);
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// result receiver stalls
	int out_stall = 0;
	always @(negedge clk) begin
		if (arst_n) begin
			if (out_fire)
				out_stall = calm ? 0 : $urandom_range(0, 4);
			else if (out_stall > 0)
				out_stall--;
			out_ready <= (out_stall == 0);
		end
	end

	task automatic write_reg(logic [2:0] idx, logic [3:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do
			@(posedge clk);
		while (!(cfg_valid && cfg_ready));
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic wait_idle();
		while (pending_elems.size() > 0 || in_valid || expected_results.size() > 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	function automatic logic signed [15:0] pick_value(bit extreme);
		logic signed [15:0] corners[5];
		corners = '{16'sh8000, 16'sh7fff, 16'sh0000, 16'shffff, 16'sh0001};
		if (extreme || $urandom_range(0, 7) == 0)
			return corners[$urandom_range(0, 4)];
		return 16'($urandom);
	endfunction

	// one complete run: A and B interleaved at random, with the odd surplus
	// element for a matrix that is already full
	function automatic int queue_run(int size_a, int size_b, bit extreme);
		int na, nb, count;
		elem_t p;
		na = 0;
		nb = 0;
		count = 0;
		while (na < size_a || nb < size_b) begin
			if ((na == size_a || nb == size_b) && $urandom_range(0, 7) == 0)
				p.kind = (na == size_a) ? KIND_A : KIND_B;
			else if (na == size_a)
				p.kind = KIND_B;
			else if (nb == size_b)
				p.kind = KIND_A;
			else
				p.kind = 1'($urandom_range(0, 1));
			if (p.kind == KIND_A && na < size_a)
				na++;
			else if (p.kind == KIND_B && nb < size_b)
				nb++;
			p.value = pick_value(extreme);
			pending_elems.push_back(p);
			count++;
		end
		return count;
	endfunction

	task automatic run_phase(logic [1:0] md, logic [3:0] ra, logic [3:0] ca,
			logic [3:0] rb, logic [3:0] cb, int runs, bit extreme, inout int issued);
		wait_idle();
		write_reg(mmas_pkg::REG_MODE, {2'b00, md});
		write_reg(mmas_pkg::REG_ROWS_A, ra);
		write_reg(mmas_pkg::REG_COLS_A, ca);
		write_reg(mmas_pkg::REG_ROWS_B, rb);
		write_reg(mmas_pkg::REG_COLS_B, cb);
		for (int i = 0; i < runs; i++)
			issued += queue_run(eff_dim(ra) * eff_dim(ca), eff_dim(rb) * eff_dim(cb), extreme);
	endtask

	function automatic logic [3:0] pick_dim();
		logic [3:0] odd[4];
		int r;
		odd = '{4'd0, 4'd8, 4'd9, 4'd15};
		r = $urandom_range(0, 15);
		if (r < 12)
			return 4'(r % 4 + 1);
		return odd[r - 12];
	endfunction

	initial begin
		int issued;
		logic [1:0] md;
		logic [3:0] ra, ca, rb, cb;
		issued = 0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		run_phase(mmas_pkg::MODE_MUL, 4'd1, 4'd1, 4'd1, 4'd1, 1, 1'b1, issued);
		run_phase(mmas_pkg::MODE_ADD, 4'd2, 4'd2, 4'd2, 4'd2, 1, 1'b1, issued);
		run_phase(mmas_pkg::MODE_SUB, 4'd1, 4'd2, 4'd1, 4'd2, 1, 1'b1, issued);
		run_phase(MODE_BAD, 4'd1, 4'd1, 4'd1, 4'd1, 1, 1'b0, issued);
		run_phase(mmas_pkg::MODE_MUL, 4'd2, 4'd3, 4'd2, 4'd2, 1, 1'b0, issued);
		run_phase(mmas_pkg::MODE_MUL, 4'd0, 4'd9, 4'd15, 4'd0, 1, 1'b1, issued);

		while (issued < 230) begin
			calm = ($urandom_range(0, 3) == 0);
			md = ($urandom_range(0, 9) == 0) ? MODE_BAD : 2'($urandom_range(0, 2));
			ra = pick_dim();
			ca = pick_dim();
			rb = pick_dim();
			cb = pick_dim();
			// keep most runs dimensionally sound
			if ($urandom_range(0, 3) != 0) begin
				if (md == mmas_pkg::MODE_MUL)
					rb = ca;
				else begin
					rb = ra;
					cb = ca;
				end
			end
			run_phase(md, ra, ca, rb, cb, $urandom_range(1, 3), 1'b0, issued);
		end

		calm = 1'b0;
		wait_idle();
		repeat (SETTLE) @(posedge clk);
		if (fail_count == 0 && expected_results.size() == 0)
			$display("** matrix_multiply_add_sub: PASSED **");
		else
			$display("** matrix_multiply_add_sub: FAILED **");
		$finish;
	end

	initial begin
		#2000000;
		$display("** matrix_multiply_add_sub: FAILED **");
		$finish;
	end

endmodule
